### hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared sizes, codes and types of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 20;
  localparam int LEN_BITS      = ADDR_BITS + 1;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
  localparam int REG_BITS      = 20;
  localparam int SIZE_BITS     = 16;
  localparam int OUT_BITS      = 20;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [REG_BITS-1:0] HEAP_BASE_RST = 20'h20000;
  localparam logic [REG_BITS-1:0] HEAP_SIZE_RST = 20'h70000;

  localparam logic [CFG_IDX_BITS-1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAP_SIZE = 2'd1;

  localparam logic FUNC_ALLOC = 1'b0;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_NOTRES = 3'd2,
    ST_FULL   = 3'd3,
    ST_ZERO   = 3'd4
  } status_t;

  typedef struct packed {
    logic                 rsv;
    logic [ADDR_BITS-1:0] base;
    logic [LEN_BITS-1:0]  len;
  } entry_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_RELOAD,
    DP_SET_RES,
    DP_SCAN_INIT,
    DP_READ_IDX,
    DP_CHECK,
    DP_MARK,
    DP_UP_INIT,
    DP_READ_UP,
    DP_WRITE_UP,
    DP_SPLIT_HI,
    DP_SPLIT_LO,
    DP_READ_NEXT,
    DP_MERGE,
    DP_READ_DN,
    DP_WRITE_DN,
    DP_SHRINK,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic func_alloc;
    logic zero_size;
    logic scan_end;
    logic hit;
    logic exact;
    logic full;
    logic up_more;
    logic dn_more;
    logic cfg_load;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RELOAD,
    S_START,
    S_READ,
    S_CHECK,
    S_ALLOC,
    S_UP_CHK,
    S_UP_WR,
    S_SPLIT_HI,
    S_SPLIT_LO,
    S_REL_NEXT,
    S_MERGE,
    S_DN_CHK,
    S_DN_WR,
    S_FINISH
  } state_t;

endpackage

### hw/rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: steps the datapath through scan, shift and merge passes.
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ffra_pkg::sts_t sts,
  output ffra_pkg::cmd_t cmd
);
  import ffra_pkg::*;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign in_stall  = !((state_r == S_IDLE) && !pend_r && !sts.cfg_load);

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = DP_NOP;
    cmd.status    = ST_OK;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          state_nxt = S_RELOAD;
        end else if (in_valid && !sts.cfg_load) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_START;
        end
      end
      S_RELOAD: begin
        cmd.op    = DP_RELOAD;
        pend_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      S_START: begin
        if (sts.func_alloc && sts.zero_size) begin
          cmd.op     = DP_SET_RES;
          cmd.status = ST_ZERO;
          state_nxt  = S_FINISH;
        end else begin
          cmd.op    = DP_SCAN_INIT;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (sts.scan_end) begin
          cmd.op     = DP_SET_RES;
          cmd.status = sts.func_alloc ? ST_NOFIT : ST_NOTRES;
          state_nxt  = S_FINISH;
        end else begin
          cmd.op    = DP_READ_IDX;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = DP_CHECK;
        if (!sts.hit) begin
          state_nxt = S_READ;
        end else if (sts.func_alloc) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_REL_NEXT;
        end
      end
      S_ALLOC: begin
        if (sts.exact) begin
          cmd.op    = DP_MARK;
          state_nxt = S_FINISH;
        end else if (sts.full) begin
          cmd.op     = DP_SET_RES;
          cmd.status = ST_FULL;
          state_nxt  = S_FINISH;
        end else begin
          cmd.op    = DP_UP_INIT;
          state_nxt = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (sts.up_more) begin
          cmd.op    = DP_READ_UP;
          state_nxt = S_UP_WR;
        end else begin
          state_nxt = S_SPLIT_HI;
        end
      end
      S_UP_WR: begin
        cmd.op    = DP_WRITE_UP;
        state_nxt = S_UP_CHK;
      end
      S_SPLIT_HI: begin
        cmd.op    = DP_SPLIT_HI;
        state_nxt = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        cmd.op    = DP_SPLIT_LO;
        state_nxt = S_FINISH;
      end
      S_REL_NEXT: begin
        cmd.op    = DP_READ_NEXT;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.op    = DP_MERGE;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.dn_more) begin
          cmd.op    = DP_READ_DN;
          state_nxt = S_DN_WR;
        end else begin
          cmd.op    = DP_SHRINK;
          state_nxt = S_FINISH;
        end
      end
      S_DN_WR: begin
        cmd.op    = DP_WRITE_DN;
        state_nxt = S_DN_CHK;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = DP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (sts.cfg_load) begin
      pend_nxt = 1'b1;
    end
  end

endmodule

### hw/rtl/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Region table memory, heap registers, scan and merge arithmetic, result word.
// ----------------------------------------------------------------------------
module ffra_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ffra_pkg::cmd_t                      cmd,
  output ffra_pkg::sts_t                      sts,
  input  logic                                in_func,
  input  logic [ffra_pkg::SIZE_BITS-1:0]      in_req_size,
  input  logic [ffra_pkg::REG_BITS-1:0]       in_release_addr,
  input  logic                                cfg_valid,
  input  logic [ffra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ffra_pkg::REG_BITS-1:0]       cfg_data,
  output logic [ffra_pkg::OUT_BITS-1:0]       out_result_addr,
  output logic [2:0]                          out_status
);
  import ffra_pkg::*;

  localparam int SUM_BITS = LEN_BITS + 1;
  localparam int CW = ((ADDR_BITS > REG_BITS) ? ADDR_BITS : REG_BITS) + 2;

  entry_t mem [TABLE_ENTRIES];

  entry_t                rd_data_r, cur_r, prev_r;
  logic [CNT_BITS-1:0]   cnt_r, idx_r, ptr_r;
  logic [1:0]            rcnt_r;
  logic                  item_func_r;
  logic [SIZE_BITS-1:0]  item_size_r;
  logic [ADDR_BITS-1:0]  item_addr_r;
  logic [REG_BITS-1:0]   heap_base_r, heap_size_r;
  status_t               res_status_r, out_status_r;
  logic [ADDR_BITS-1:0]  res_addr_r;
  logic [OUT_BITS-1:0]   out_addr_r;

  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr, rd_addr;
  entry_t                wr_data;

  logic [LEN_BITS-1:0]   size_len, merged_len;
  logic                  hit, has_next, merge_next, merge_prev;
  logic [CNT_BITS-1:0]   idx_inc, tgt, up_src, dn_src;
  logic [ADDR_BITS-1:0]  rl_base;
  logic [CW-1:0]         room, hsz;
  logic [LEN_BITS-1:0]   rl_len;
  logic                  cfg_load;

  assign size_len = LEN_BITS'(item_size_r);
  assign idx_inc  = idx_r + 1'b1;
  assign up_src   = ptr_r - 1'b1;
  assign dn_src   = ptr_r + CNT_BITS'(rcnt_r);

  // first fit for allocate, exact reserved base for release
  assign hit = (item_func_r == FUNC_ALLOC)
             ? (!rd_data_r.rsv && (rd_data_r.len >= size_len))
             : (rd_data_r.rsv && (rd_data_r.base == item_addr_r));

  // rd_data_r holds the upper neighbor during the merge step
  assign has_next   = idx_inc < cnt_r;
  assign merge_next = has_next && !rd_data_r.rsv &&
                      ((SUM_BITS'(cur_r.base) + SUM_BITS'(cur_r.len)) ==
                       SUM_BITS'(rd_data_r.base));
  assign merge_prev = (idx_r != '0) && !prev_r.rsv &&
                      ((SUM_BITS'(prev_r.base) + SUM_BITS'(prev_r.len)) ==
                       SUM_BITS'(cur_r.base));
  assign merged_len = (merge_prev ? prev_r.len : '0) + cur_r.len +
                      (merge_next ? rd_data_r.len : '0);
  assign tgt        = merge_prev ? (idx_r - 1'b1) : idx_r;

  // clip the heap at the top of the address space
  assign rl_base = ADDR_BITS'(heap_base_r);
  assign room    = (CW'(1) << ADDR_BITS) - CW'(rl_base);
  assign hsz     = CW'(heap_size_r);
  assign rl_len  = LEN_BITS'((hsz > room) ? room : hsz);

  assign cfg_load = cfg_valid &&
                    ((cfg_index == REG_HEAP_BASE) || (cfg_index == REG_HEAP_SIZE));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[IDX_BITS-1:0];
    wr_data = cur_r;
    rd_addr = idx_r[IDX_BITS-1:0];
    unique case (cmd.op)
      DP_RELOAD: begin
        wr_en        = 1'b1;
        wr_addr      = '0;
        wr_data.rsv  = 1'b0;
        wr_data.base = rl_base;
        wr_data.len  = rl_len;
      end
      DP_MARK: begin
        wr_en       = 1'b1;
        wr_data.rsv = 1'b1;
      end
      DP_READ_UP:  rd_addr = up_src[IDX_BITS-1:0];
      DP_WRITE_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_BITS-1:0];
        wr_data = rd_data_r;
      end
      DP_SPLIT_HI: begin
        wr_en        = 1'b1;
        wr_addr      = idx_inc[IDX_BITS-1:0];
        wr_data.rsv  = 1'b0;
        wr_data.base = cur_r.base + ADDR_BITS'(item_size_r);
        wr_data.len  = cur_r.len - size_len;
      end
      DP_SPLIT_LO: begin
        wr_en       = 1'b1;
        wr_data.rsv = 1'b1;
        wr_data.len = size_len;
      end
      DP_READ_NEXT: rd_addr = idx_inc[IDX_BITS-1:0];
      DP_MERGE: begin
        wr_en        = 1'b1;
        wr_addr      = tgt[IDX_BITS-1:0];
        wr_data.rsv  = 1'b0;
        wr_data.base = merge_prev ? prev_r.base : cur_r.base;
        wr_data.len  = merged_len;
      end
      DP_READ_DN:  rd_addr = dn_src[IDX_BITS-1:0];
      DP_WRITE_DN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_BITS-1:0];
        wr_data = rd_data_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= HEAP_BASE_RST;
      heap_size_r <= HEAP_SIZE_RST;
      cnt_r       <= CNT_BITS'(1);
    end else begin
      if (cfg_valid && (cfg_index == REG_HEAP_BASE)) begin
        heap_base_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_HEAP_SIZE)) begin
        heap_size_r <= cfg_data;
      end
      unique case (cmd.op)
        DP_LOAD: begin
          item_func_r <= in_func;
          item_size_r <= in_req_size;
          item_addr_r <= ADDR_BITS'(in_release_addr);
        end
        DP_RELOAD: cnt_r <= CNT_BITS'(1);
        DP_SET_RES: begin
          res_status_r <= cmd.status;
          res_addr_r   <= '0;
        end
        DP_SCAN_INIT: idx_r <= '0;
        DP_CHECK: begin
          cur_r <= rd_data_r;
          if (!hit) begin
            prev_r <= rd_data_r;
            idx_r  <= idx_inc;
          end
        end
        DP_MARK: begin
          res_status_r <= ST_OK;
          res_addr_r   <= cur_r.base;
        end
        DP_UP_INIT:  ptr_r <= cnt_r;
        DP_WRITE_UP: ptr_r <= up_src;
        DP_SPLIT_LO: begin
          cnt_r        <= cnt_r + 1'b1;
          res_status_r <= ST_OK;
          res_addr_r   <= cur_r.base;
        end
        DP_MERGE: begin
          ptr_r        <= tgt + 1'b1;
          rcnt_r       <= {1'b0, merge_next} + {1'b0, merge_prev};
          res_status_r <= ST_OK;
          res_addr_r   <= '0;
        end
        DP_WRITE_DN: ptr_r <= ptr_r + 1'b1;
        DP_SHRINK:   cnt_r <= cnt_r - CNT_BITS'(rcnt_r);
        DP_PUBLISH: begin
          out_status_r <= res_status_r;
          out_addr_r   <= OUT_BITS'(res_addr_r);
        end
        default: ;
      endcase
    end
  end

  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

  assign sts.func_alloc = (item_func_r == FUNC_ALLOC);
  assign sts.zero_size  = (item_size_r == '0);
  assign sts.scan_end   = (idx_r == cnt_r);
  assign sts.hit        = hit;
  assign sts.exact      = (cur_r.len == size_len);
  assign sts.full       = (cnt_r == CNT_BITS'(TABLE_ENTRIES));
  assign sts.up_more    = (ptr_r > idx_inc);
  assign sts.dn_more    = (rcnt_r != '0) && (dn_src < cnt_r);
  assign sts.cfg_load   = cfg_load;

endmodule

### hw/rtl/first_fit_region_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top
// First-fit heap region allocator with coalescing of freed neighbors.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per request, in_func selects
//   allocate (in_req_size bytes) or release (region based at in_release_addr).
// Result channel (out_valid / out_stall): one word per request, the allocated
//   base in out_result_addr (zero otherwise) and a code in out_status.
// Config channel (cfg_valid / cfg_ready): index 0 heap base, 1 heap size; a
//   write to either reloads the table as one free region. cfg_ready is always high.
// Operation: one request at a time. The region table lives in a memory with
//   registered read; the scan visits entries in order until a hit, a split
//   moves every entry above the hit up by one, and a release merge moves
//   the entries above it down. The scan and the shift never cover the same
//   entries.
// Reset: heap registers load their defaults and a reload step writes the
//   single free region; in_stall stays high until it is done.
// Stall: the result register holds while out_stall is high; the next request
//   is accepted and processed, then waits in the datapath for the register.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [ffra_pkg::SIZE_BITS-1:0]    in_req_size,
  input  logic [ffra_pkg::REG_BITS-1:0]     in_release_addr,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ffra_pkg::OUT_BITS-1:0]     out_result_addr,
  output logic [2:0]                        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffra_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ffra_pkg::REG_BITS-1:0]     cfg_data
);
  import ffra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config must only be written while idle (the block does not enforce it), so accept it at once
  assign cfg_ready = 1'b1;

  ffra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffra_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_req_size     (in_req_size),
    .in_release_addr (in_release_addr),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_result_addr (out_result_addr),
    .out_status      (out_status)
  );

endmodule

### hw/rtl/ffra_chk.sv
// ----------------------------------------------------------------------------
// ffra_chk
// Port-level checks of the allocator's result channel.
// ----------------------------------------------------------------------------
module ffra_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ffra_pkg::OUT_BITS-1:0] out_result_addr,
  input logic [2:0]                    out_status
);
  import ffra_pkg::*;

  // hold a stalled result
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_addr) && $stable(out_status))
    else $error("stalled result changed");

  // failures never carry an address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_result_addr == '0))
    else $error("failed request returned an address");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_NOFIT) ||
                  (out_status == ST_NOTRES) || (out_status == ST_FULL) ||
                  (out_status == ST_ZERO))
    else $error("undefined status code");

endmodule

bind first_fit_region_allocator_top ffra_chk u_ffra_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_addr (out_result_addr),
  .out_status      (out_status)
);

### test/ffra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request, result and config channels of the region allocator,
// keeps its own copy of the region table, and checks every result word.
// ----------------------------------------------------------------------------
module ffra_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_func,
  input  logic [ffra_pkg::SIZE_BITS-1:0]    in_req_size,
  input  logic [ffra_pkg::REG_BITS-1:0]     in_release_addr,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ffra_pkg::OUT_BITS-1:0]     out_result_addr,
  input  logic [2:0]                        out_status,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ffra_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ffra_pkg::REG_BITS-1:0]     cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                checked,
  output logic [7:0][ffra_pkg::ADDR_BITS-1:0] recent_bases
);
  import ffra_pkg::*;

  logic [REG_BITS-1:0]  heap_base_q, heap_size_q;
  logic [ADDR_BITS-1:0] rgn_base [TABLE_ENTRIES];
  logic [LEN_BITS-1:0]  rgn_len  [TABLE_ENTRIES];
  logic                 rgn_rsv  [TABLE_ENTRIES];
  int                   rgn_cnt;
  int                   recent_wr;

  logic [OUT_BITS-1:0]  want_addr_q [$];
  status_t              want_status_q [$];

  task automatic reload_regions();
    logic [LEN_BITS-1:0] room;
    room = (LEN_BITS'(1) << ADDR_BITS) - LEN_BITS'(heap_base_q);
    rgn_base[0] = heap_base_q;
    rgn_len[0]  = (LEN_BITS'(heap_size_q) > room) ? room : LEN_BITS'(heap_size_q);
    rgn_rsv[0]  = 1'b0;
    rgn_cnt     = 1;
  endtask

  task automatic drop_region(input int j);
    for (int k = j; k + 1 < rgn_cnt; k++) begin
      rgn_base[k] = rgn_base[k+1];
      rgn_len[k]  = rgn_len[k+1];
      rgn_rsv[k]  = rgn_rsv[k+1];
    end
    rgn_cnt--;
  endtask

  task automatic alloc_region(input logic [SIZE_BITS-1:0] sz,
                              output logic [OUT_BITS-1:0] addr, output status_t st);
    int i;
    addr = '0;
    st   = ST_OK;
    if (sz == 0) begin
      st = ST_ZERO;
      return;
    end
    for (i = 0; i < rgn_cnt; i++)
      if (!rgn_rsv[i] && rgn_len[i] >= LEN_BITS'(sz)) break;
    if (i >= rgn_cnt) begin
      st = ST_NOFIT;
      return;
    end
    if (rgn_len[i] != LEN_BITS'(sz)) begin
      if (rgn_cnt >= TABLE_ENTRIES) begin
        st = ST_FULL;
        return;
      end
      for (int k = rgn_cnt; k > i + 1; k--) begin
        rgn_base[k] = rgn_base[k-1];
        rgn_len[k]  = rgn_len[k-1];
        rgn_rsv[k]  = rgn_rsv[k-1];
      end
      rgn_base[i+1] = rgn_base[i] + ADDR_BITS'(sz);
      rgn_len[i+1]  = rgn_len[i] - LEN_BITS'(sz);
      rgn_rsv[i+1]  = 1'b0;
      rgn_len[i]    = LEN_BITS'(sz);
      rgn_cnt++;
    end
    rgn_rsv[i] = 1'b1;
    addr = rgn_base[i];
    recent_bases[recent_wr] = rgn_base[i];
    recent_wr = (recent_wr + 1) % 8;
  endtask

  task automatic release_region(input logic [ADDR_BITS-1:0] where, output status_t st);
    int i;
    st = ST_OK;
    for (i = 0; i < rgn_cnt; i++)
      if (rgn_rsv[i] && rgn_base[i] == where) break;
    if (i >= rgn_cnt) begin
      st = ST_NOTRES;
      return;
    end
    rgn_rsv[i] = 1'b0;
    // merge upward first, then fold into the region below
    if (i + 1 < rgn_cnt && !rgn_rsv[i+1] &&
        LEN_BITS'(rgn_base[i]) + rgn_len[i] == LEN_BITS'(rgn_base[i+1])) begin
      rgn_len[i] = rgn_len[i] + rgn_len[i+1];
      drop_region(i + 1);
    end
    if (i > 0 && !rgn_rsv[i-1] &&
        LEN_BITS'(rgn_base[i-1]) + rgn_len[i-1] == LEN_BITS'(rgn_base[i])) begin
      rgn_len[i-1] = rgn_len[i-1] + rgn_len[i];
      drop_region(i);
    end
  endtask

  always @(posedge clk) begin
    logic [OUT_BITS-1:0] a;
    status_t             st;
    if (!rst_n) begin
      heap_base_q  = HEAP_BASE_RST;
      heap_size_q  = HEAP_SIZE_RST;
      reload_regions();
      want_addr_q.delete();
      want_status_q.delete();
      fail_count   = 0;
      checked      = 0;
      recent_wr    = 0;
      recent_bases = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEAP_BASE) begin
          heap_base_q = cfg_data;
          reload_regions();
        end else if (cfg_index == REG_HEAP_SIZE) begin
          heap_size_q = cfg_data;
          reload_regions();
        end
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (want_addr_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word addr=%h status=%0d",
                     $realtime, out_result_addr, out_status);
        end else begin
          a  = want_addr_q.pop_front();
          st = want_status_q.pop_front();
          if (out_result_addr !== a || out_status !== st) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch addr exp=%h act=%h status exp=%0d act=%0d",
                       $realtime, a, out_result_addr, st, out_status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_ALLOC) alloc_region(in_req_size, a, st);
        else begin
          a = '0;
          release_region(in_release_addr, st);
        end
        want_addr_q.push_back(a);
        want_status_q.push_back(st);
      end
    end
    pending = want_addr_q.size();
  end

endmodule

### test/first_fit_region_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top_tb
// Drives allocate and release requests through the region allocator over
// several heap settings and handshake pressure levels; a side checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_top_tb;
  import ffra_pkg::*;

  localparam int                      WATCHDOG_LIMIT = 6000;
  localparam int                      HOLD_CYCLES    = 400;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED     = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_func;
  logic [SIZE_BITS-1:0]    in_req_size;
  logic [REG_BITS-1:0]     in_release_addr;
  logic                    out_valid;
  logic                    out_stall;
  logic [OUT_BITS-1:0]     out_result_addr;
  logic [2:0]              out_status;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0]     cfg_data;

  int                      fail_count, pending, checked;
  logic [7:0][ADDR_BITS-1:0] recent_bases;

  int idle_pct, stall_pct, hold_left, quiet_cycles, words_sent;

  first_fit_region_allocator_top i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_req_size, .in_release_addr,
    .out_valid, .out_stall, .out_result_addr, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ffra_checker i_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_func, .in_req_size, .in_release_addr,
    .out_valid, .out_stall, .out_result_addr, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .checked, .recent_bases
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result side: stall at the current rate, or hold off completely while a
  // long back-pressure stretch is running so the allocator fills up.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: count cycles where no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d words outstanding", pending);
        $display("first_fit_region_allocator_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Offer one request word, with random idle cycles ahead of it; hold the
  // word until the allocator takes it.
  task automatic send_word(input logic func, input logic [SIZE_BITS-1:0] sz,
                           input logic [REG_BITS-1:0] where);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_req_size     <= sz;
    in_release_addr <= where;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic alloc(input logic [SIZE_BITS-1:0] sz);
    send_word(FUNC_ALLOC, sz, REG_BITS'($urandom));
  endtask

  task automatic free(input logic [REG_BITS-1:0] where);
    send_word(~FUNC_ALLOC, SIZE_BITS'($urandom), where);
  endtask

  // Drain, let the datapath settle, then write one register.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [REG_BITS-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_heap(input logic [REG_BITS-1:0] b, input logic [REG_BITS-1:0] s);
    write_reg(REG_HEAP_BASE, b);
    write_reg(REG_HEAP_SIZE, s);
  endtask

  // Mostly well-formed traffic: releases aim at recently allocated bases,
  // sizes mostly small, with some full-range sizes and stray addresses.
  task automatic random_traffic(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45)      alloc(SIZE_BITS'($urandom_range(1, 2048)));
      else if (r < 52) alloc(SIZE_BITS'($urandom));
      else if (r < 55) alloc('0);
      else if (r < 90) free(recent_bases[$urandom_range(7)]);
      else             free(REG_BITS'($urandom));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_ALLOC;
    in_req_size     = '0;
    in_release_addr = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_HEAP_BASE;
    cfg_data        = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    words_sent      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Default heap straight out of reset, no idling.
    alloc(16'hFFFF);
    alloc(16'h0001);
    free(20'h20000);
    free(20'h20000);
    random_traffic(60);

    // Small heap: exact fit, merges on both sides, no fit, bad releases.
    set_heap(20'h00100, 20'h00100);
    alloc(16'h0010);
    alloc(16'h0010);
    alloc(16'h0010);
    free(20'h00110);
    alloc(16'h0010);
    free(20'h00100);
    free(20'h00120);
    free(20'h00110);
    alloc(16'h0100);
    alloc(16'h0001);
    free(20'h00100);
    free(20'h00100);
    alloc(16'h0000);
    free(20'hFFFFF);

    // Fill the table to its last entry, then force a split that cannot fit.
    set_heap(20'h01000, 20'h10000);
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) alloc(SIZE_BITS'($urandom_range(1, 16)));
    alloc(16'h0001);
    alloc(16'h0002);
    random_traffic(20);

    // Whole address space, sender idling.
    idle_pct = 67;
    set_heap(20'h00000, 20'hFFFFF);
    random_traffic(90);

    // Heap clipped at the top of the address space, receiver stalling,
    // plus one long hold-off while requests keep coming.
    idle_pct  = 0;
    stall_pct = 67;
    set_heap(20'hFFFF0, 20'hFFFFF);
    alloc(16'h0010);
    alloc(16'h0001);
    set_heap(20'h12345, 20'h03000);
    hold_left = HOLD_CYCLES;
    random_traffic(90);

    // Zero-size heap and a register index that does not exist, both idling.
    idle_pct  = 33;
    stall_pct = 33;
    set_heap(20'h80000, 20'h00000);
    alloc(16'h0001);
    alloc(16'hFFFF);
    write_reg(REG_UNUSED, 20'h00040);
    alloc(16'h0001);
    set_heap(20'h45678, 20'h00001);
    alloc(16'h0001);
    alloc(16'h0001);
    set_heap(20'h40000, 20'h40000);
    random_traffic(90);

    // Back to no idling on a mid-size heap.
    idle_pct  = 0;
    stall_pct = 0;
    set_heap(20'hA5A5A, 20'h0C000);
    random_traffic(80);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("sent %0d request words over 10 heap settings and 4 handshake modes,", words_sent);
    $display("checked %0d result words, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("first_fit_region_allocator_top_tb: PASS");
    end else begin
      $display("first_fit_region_allocator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
